// ===== rtl/core/rbe_pkg.sv =====
// rbe_pkg: shared types, constants and the control program of the Rosenbrock evaluator.
// Used by rbe_seq (step sequencer) and rosenbrock_evaluator (datapath, top level).
// No dependencies.
package rbe_pkg;

  // Number format
  localparam int FRAC_BITS        = 11;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int VALUE_W          = 63;
  localparam int OUT_TDATA_W      = 64;
  localparam int SCALE            = 100;

  // Datapath widths: one MUL_W x MUL_W multiplier, difference magnitude kept to DMAG_W bits.
  // Any |x*2^11 - p^2| of 2^40 or more drives the scaled term past the maximum anyway.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DMAG_W = 40;
  localparam int SQ_W   = 2 * DMAG_W;
  localparam int AQ_W   = SQ_W - 2 * FRAC_BITS;
  localparam int PC_W   = 3;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  // Largest square that can still be scaled without saturating
  localparam logic [VALUE_W-1:0] A_LIMIT   = VALUE_MAX / SCALE;
  localparam logic signed [63:0] ONE_Q     = 64'sd1 <<< FRAC_BITS;

  typedef logic [PC_W-1:0] pc_t;

  // Multiplier operand sources
  typedef enum logic [1:0] {
    OP_PMAG,
    OP_EMAG,
    OP_DLO,
    OP_DHI
  } mul_op_t;

  // Square accumulator operations
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_MID,
    ACC_HI
  } acc_op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_NONE,
    JC_FIRST,
    JC_DHI_ZERO
  } jump_t;

  typedef struct packed {
    mul_op_t op_a;
    mul_op_t op_b;
    acc_op_t acc;
    logic    ld_d;
    logic    ld_b;
    logic    ld_a;
    logic    fin;
    jump_t   jmp;
    pc_t     target;
  } ctrl_t;

  // Sequencer inputs from the datapath
  typedef struct packed {
    logic start;
    logic hold;
    logic first;
    logic dhi_zero;
  } seq_in_t;

  // Step addresses
  localparam pc_t PC_SQ_P   = 3'd0;
  localparam pc_t PC_DIFF   = 3'd1;
  localparam pc_t PC_SQ_LO  = 3'd2;
  localparam pc_t PC_SQ_MID = 3'd3;
  localparam pc_t PC_SQ_HI  = 3'd4;
  localparam pc_t PC_ACC_HI = 3'd5;
  localparam pc_t PC_SCALE  = 3'd6;
  localparam pc_t PC_FIN    = 3'd7;

  localparam ctrl_t CTRL_NOP = '{
    op_a: OP_PMAG, op_b: OP_PMAG, acc: ACC_HOLD, ld_d: 1'b0, ld_b: 1'b0,
    ld_a: 1'b0, fin: 1'b0, jmp: JC_NONE, target: PC_SQ_P
  };

  // Control store: one word per step
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t c;
    c = CTRL_NOP;
    case (pc)
      PC_SQ_P: begin        // p^2; first element of a vector has no term
        c.op_a   = OP_PMAG;
        c.op_b   = OP_PMAG;
        c.jmp    = JC_FIRST;
        c.target = PC_FIN;
      end
      PC_DIFF: begin        // d = x*2^11 - p^2; (p-1)^2
        c.ld_d = 1'b1;
        c.op_a = OP_EMAG;
        c.op_b = OP_EMAG;
      end
      PC_SQ_LO: begin       // keep (p-1)^2; dlo^2
        c.ld_b = 1'b1;
        c.op_a = OP_DLO;
        c.op_b = OP_DLO;
      end
      PC_SQ_MID: begin      // load dlo^2; dlo*dhi; skip upper part when dhi is zero
        c.acc    = ACC_LOAD;
        c.op_a   = OP_DLO;
        c.op_b   = OP_DHI;
        c.jmp    = JC_DHI_ZERO;
        c.target = PC_SCALE;
      end
      PC_SQ_HI: begin       // add 2*dlo*dhi; dhi^2
        c.acc  = ACC_MID;
        c.op_a = OP_DHI;
        c.op_b = OP_DHI;
      end
      PC_ACC_HI: begin      // add dhi^2
        c.acc = ACC_HI;
      end
      PC_SCALE: begin       // 100 * (d^2 >> 22), saturated
        c.ld_a = 1'b1;
      end
      PC_FIN: begin         // sum update, result, state update
        c.fin = 1'b1;
      end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/rosenbrock_evaluator.sv =====
// rosenbrock_evaluator: top level, fixed-point Rosenbrock function over a stream of variables.
// Depends on rbe_pkg and rbe_seq.
//
// Usage:
//   Input beats carry one signed variable each (11 fraction bits) in in_tdata; in_tlast
//   marks the last variable of a vector. For each variable after the first, with p the
//   one before it, 100*(x - p^2)^2 + (p - 1)^2 is added to a saturating running sum.
//   The last variable produces one output beat: out_tdata holds the value (22 fraction
//   bits, held at 2^63-1 on overflow) and out_tuser the status (1 when the vector had
//   a single variable, value then 2^63-1). Vector state is cleared after each result.
// Timing:
//   One 32x32 multiplier is shared by a microcoded sequence. A variable runs the steps
//   p^2, difference, low square, mid product, scale and finish, plus the upper square
//   steps when |x*2^11 - p^2| reaches 2^32 (only at SAMPLE_WIDTH above 16); the first
//   variable of a vector runs only p^2 and finish. The next beat is accepted in the
//   finish cycle of the current one. The result shows on out_tvalid the cycle after finish.
// Reset and stalls:
//   rst_n (synchronous, active low) clears the sequencer, vector state and out_tvalid.
//   One result waits in the output register while later variables keep coming in; a
//   second result waits in its finish step until the first is taken, holding in_tready.
module rosenbrock_evaluator #(
  parameter int SAMPLE_WIDTH = rbe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,   // [SAMPLE_WIDTH-1:0] x_value
  input  logic                                in_tlast,   // last
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rbe_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [62:0] value
  output logic [0:0]                          out_tuser   // [0] status
);
  import rbe_pkg::*;

  // Sequencer
  seq_in_t sin;
  ctrl_t   ctrl;
  logic    busy;

  rbe_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .sin  (sin),
    .busy (busy),
    .ctrl (ctrl)
  );

  // Registers
  logic signed [SAMPLE_WIDTH-1:0] x_r, prev_r, prev_nxt;
  logic                           last_r;
  logic [1:0]                     count_r, count_nxt;
  logic [VALUE_W-1:0]             sum_r, sum_nxt;
  logic [PROD_W-1:0]              prod_r;
  logic [DMAG_W-1:0]              d_r;
  logic                           dsat_r;
  logic [SQ_W-1:0]                sq_r, sq_nxt;
  logic [VALUE_W-1:0]             a_r, b_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]             out_value_r;
  logic                           out_status_r;

  // Combinational values
  logic signed [63:0]  p_ext, x_ext, e_diff, d_full;
  logic [63:0]         pmag, emag, dmag;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   product;
  logic [AQ_W-1:0]     a_q;
  logic [VALUE_W-1:0]  a_scaled, b_sat, new_sum;
  logic [VALUE_W+1:0]  total;
  logic                start, hold, emit, dhi_zero;

  function automatic logic [MUL_W-1:0] operand(input mul_op_t op, input logic [63:0] pm,
                                               input logic [63:0] em,
                                               input logic [DMAG_W-1:0] d);
    logic [MUL_W-1:0] v;
    case (op)
      OP_PMAG: v = pm[MUL_W-1:0];
      OP_EMAG: v = em[MUL_W-1:0];
      OP_DLO:  v = d[MUL_W-1:0];
      OP_DHI:  v = MUL_W'(d[DMAG_W-1:MUL_W]);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Handshake and sequencer conditions
  assign dhi_zero     = (d_r[DMAG_W-1:MUL_W] == '0);
  assign emit         = ctrl.fin && last_r;
  assign hold         = emit && out_valid_r && !out_tready;
  assign in_tready    = !busy || (ctrl.fin && !hold);
  assign start        = in_tvalid && in_tready;
  assign sin.start    = start;
  assign sin.hold     = hold;
  assign sin.first    = (count_r == 2'd0);
  assign sin.dhi_zero = dhi_zero;

  // Magnitudes of p, p - 1 and the difference x*2^11 - p^2
  always_comb begin
    p_ext  = 64'(prev_r);
    x_ext  = 64'(x_r);
    pmag   = p_ext[63] ? 64'(-p_ext) : 64'(p_ext);
    e_diff = p_ext - ONE_Q;
    emag   = e_diff[63] ? 64'(-e_diff) : 64'(e_diff);
    d_full = (x_ext <<< FRAC_BITS) - signed'(prod_r);
    dmag   = d_full[63] ? 64'(-d_full) : 64'(d_full);
  end

  // Shared multiplier
  always_comb begin
    mul_a   = operand(ctrl.op_a, pmag, emag, d_r);
    mul_b   = operand(ctrl.op_b, pmag, emag, d_r);
    product = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Square accumulator: dlo^2 + 2*dlo*dhi*2^32 + dhi^2*2^64
  always_comb begin
    case (ctrl.acc)
      ACC_LOAD: sq_nxt = SQ_W'(prod_r);
      ACC_MID:  sq_nxt = sq_r + (SQ_W'(prod_r) << (MUL_W + 1));
      ACC_HI:   sq_nxt = sq_r + (SQ_W'(prod_r) << (2 * MUL_W));
      default:  sq_nxt = sq_r;
    endcase
  end

  // Scale by 100 as shifts (64 + 32 + 4), saturating
  always_comb begin
    a_q = sq_r[SQ_W-1:2*FRAC_BITS];
    if (dsat_r || (VALUE_W'(a_q) > A_LIMIT)) begin
      a_scaled = VALUE_MAX;
    end else begin
      a_scaled = (VALUE_W'(a_q) << 6) + (VALUE_W'(a_q) << 5) + (VALUE_W'(a_q) << 2);
    end
    b_sat = prod_r[PROD_W-1] ? VALUE_MAX : prod_r[VALUE_W-1:0];
  end

  // Running sum with both terms, saturating
  always_comb begin
    total   = (VALUE_W+2)'(sum_r) + (VALUE_W+2)'(a_r) + (VALUE_W+2)'(b_r);
    new_sum = (total > (VALUE_W+2)'(VALUE_MAX)) ? VALUE_MAX : total[VALUE_W-1:0];
  end

  // Vector state and output register next values
  always_comb begin
    prev_nxt      = prev_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (ctrl.fin && !hold) begin
      if (last_r) begin
        prev_nxt      = '0;
        count_nxt     = 2'd0;
        sum_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else begin
        prev_nxt  = x_r;
        count_nxt = (count_r == 2'd2) ? 2'd2 : count_r + 2'd1;
        if (count_r != 2'd0) sum_nxt = new_sum;
      end
    end
  end

  // Control and vector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      count_r     <= 2'd0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= signed'(in_tdata[SAMPLE_WIDTH-1:0]);
      last_r <= in_tlast;
    end
    prod_r <= product;
    sq_r   <= sq_nxt;
    if (ctrl.ld_d) begin
      d_r    <= dmag[DMAG_W-1:0];
      dsat_r <= (dmag[63:DMAG_W] != '0);
    end
    if (ctrl.ld_b) b_r <= b_sat;
    if (ctrl.ld_a) a_r <= a_scaled;
    if (emit && !hold) begin
      out_value_r  <= (count_r == 2'd0) ? VALUE_MAX : new_sum;
      out_status_r <= (count_r == 2'd0);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_TDATA_W'(out_value_r);
  assign out_tuser[0] = out_status_r;

  // Checks
  a_err_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[VALUE_W-1:0] == VALUE_MAX)
    else $error("error status without maximum value");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("element count past two");

  a_mid_skip: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.acc == ACC_MID |-> !dhi_zero)
    else $error("upper square steps run with a zero upper difference");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && busy |-> ctrl.fin && !hold)
    else $error("beat accepted in the middle of a sequence");

endmodule

// ===== rtl/core/rbe_seq.sv =====
// rbe_seq: step counter and control store walker for the Rosenbrock evaluator.
// Depends on rbe_pkg (ctrl_t, seq_in_t, ucode).
module rbe_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  rbe_pkg::seq_in_t sin,
  output logic            busy,
  output rbe_pkg::ctrl_t  ctrl
);
  import rbe_pkg::*;

  logic  busy_r, busy_nxt;
  pc_t   pc_r, pc_nxt;
  ctrl_t word;
  logic  taken;

  // Current control word
  always_comb word = ucode(pc_r);

  // Jump condition
  always_comb begin
    case (word.jmp)
      JC_FIRST:    taken = sin.first;
      JC_DHI_ZERO: taken = sin.dhi_zero;
      default:     taken = 1'b0;
    endcase
  end

  // Next step; a new beat may start in the finish step
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (sin.start) begin
        busy_nxt = 1'b1;
        pc_nxt   = PC_SQ_P;
      end
    end else if (!sin.hold) begin
      if (word.fin) begin
        busy_nxt = sin.start;
        pc_nxt   = PC_SQ_P;
      end else if (taken) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_SQ_P;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy = busy_r;
  assign ctrl = busy_r ? word : CTRL_NOP;

endmodule

// ===== sim/rbe_checker.sv =====
// rbe_checker: watches the input and result streams of the Rosenbrock evaluator, predicts
// each result from the accepted input beats and compares it field by field.
// Depends on rbe_pkg.
module rbe_checker #(
  parameter int SAMPLE_WIDTH = rbe_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,   // [SAMPLE_WIDTH-1:0] x_value
  input  logic                                in_tlast,   // last
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [rbe_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [62:0] value
  input  logic [0:0]                          out_tuser,  // [0] status
  output int                                  fail_count,
  output int                                  pending,
  output int                                  results_checked
);
  import rbe_pkg::*;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef struct packed {
    value_t value;
    logic   status;
  } fvalue_t;

  // Vector state of the predictor
  sample_t prev_x = '0;
  logic [1:0] elem_count = '0;
  value_t  run_sum = '0;

  fvalue_t fvalue_q[$];
  int errors = 0;
  int checked = 0;

  function automatic value_t sat_add(input value_t a, input value_t b);
    logic [VALUE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VALUE_W] ? VALUE_MAX : s[VALUE_W-1:0];
  endfunction

  // 100*(x - p^2)^2 + (p - 1)^2 at 22 fraction bits, every step clamped to the maximum
  function automatic value_t pair_term(input sample_t p, input sample_t x);
    logic signed [127:0] pw, xw, diff, off;
    logic [127:0] dmag, emag, wide;
    value_t a, b;
    pw   = p;
    xw   = x;
    diff = (xw <<< FRAC_BITS) - pw * pw;
    dmag = (diff < 0) ? -diff : diff;
    wide = (dmag * dmag) >> (2 * FRAC_BITS);
    a    = (wide > {65'd0, VALUE_MAX}) ? VALUE_MAX : wide[VALUE_W-1:0];
    wide = {65'd0, a} * 128'd100;
    a    = (wide > {65'd0, VALUE_MAX}) ? VALUE_MAX : wide[VALUE_W-1:0];
    off  = pw - (128'sd1 <<< FRAC_BITS);
    emag = (off < 0) ? -off : off;
    wide = emag * emag;
    b    = (wide > {65'd0, VALUE_MAX}) ? VALUE_MAX : wide[VALUE_W-1:0];
    return sat_add(a, b);
  endfunction

  // Folds one variable into the vector; returns 1 when it closes the vector
  function automatic bit take_element(input sample_t x, input logic last, output fvalue_t r);
    if (elem_count != 2'd0)
      run_sum = sat_add(run_sum, pair_term(prev_x, x));
    if (elem_count == 2'd0) begin
      r = '{value: VALUE_MAX, status: 1'b1};
    end else begin
      r = '{value: run_sum, status: 1'b0};
    end
    if (last) begin
      prev_x     = '0;
      elem_count = '0;
      run_sum    = '0;
      return 1'b1;
    end
    prev_x = x;
    if (elem_count != 2'd2)
      elem_count = elem_count + 2'd1;
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    fvalue_t want;
    fvalue_t got;
    if (!rst_n) begin
      prev_x     = '0;
      elem_count = '0;
      run_sum    = '0;
      fvalue_q.delete();
    end else begin
      // input beat: predict
      if (in_tvalid && in_tready) begin
        if (take_element(sample_t'(in_tdata[SAMPLE_WIDTH-1:0]), in_tlast, want))
          fvalue_q.push_back(want);
      end
      // result beat: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        got = '{value: out_tdata[VALUE_W-1:0], status: out_tuser[0]};
        if (fvalue_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: value %h status %0d",
                   $time, got.value, got.status);
        end else begin
          want = fvalue_q.pop_front();
          checked++;
          if (got.value !== want.value) begin
            errors++;
            $display("%0t: value mismatch: expected %h actual %h",
                     $time, want.value, got.value);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
          end
        end
      end
    end
    fail_count      <= errors;
    pending         <= fvalue_q.size();
    results_checked <= checked;
  end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: stimulus and verdict for rosenbrock_evaluator; directed vectors, then random
// vectors under four idle/stall phases. Depends on rbe_pkg, rosenbrock_evaluator, rbe_checker.
module tb_top;
  import rbe_pkg::*;

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int IN_W        = ((SW + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 295;

  localparam logic [SW-1:0] X_MIN  = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] X_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] X_ONE  = SW'(1 << FRAC_BITS);
  localparam logic [SW-1:0] X_NEG1 = '1;
  localparam logic [SW-1:0] X_LSB  = SW'(1);
  localparam logic [SW-1:0] X_ZERO = '0;

  // Value mixes for random vectors
  typedef enum int {
    MIX_FULL,
    MIX_NEAR_ONE,
    MIX_SMALL,
    MIX_EXTREME
  } sample_mix_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  int fail_count;
  int pending;
  int results_checked;

  int idle_pct = 0;
  int stall_pct = 0;
  int elems_sent = 0;
  int vectors_sent = 0;
  int singles = 0;
  int quiet = 0;
  logic [SW-1:0] vec_buf[$];

  always #10 clk = ~clk;

  rosenbrock_evaluator #(.SAMPLE_WIDTH(SW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rbe_checker #(.SAMPLE_WIDTH(SW)) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: cycles without any beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding", $time, quiet, pending);
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [SW-1:0] pick_sample(input sample_mix_t mix);
    logic [SW-1:0] v;
    v = SW'($urandom);
    case (mix)
      MIX_NEAR_ONE: v = X_ONE + SW'($urandom_range(0, 1023)) - SW'(512);
      MIX_SMALL:    v = SW'($urandom_range(0, 8191)) - SW'(4096);
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = X_MIN;
          1: v = X_MAX;
          2: v = X_NEG1;
          3: v = X_ZERO;
          default: ;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // Sends vec_buf as one vector, tlast on its final beat
  task automatic send_vector();
    logic [IN_W-1:0] word;
    for (int i = 0; i < vec_buf.size(); i++) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      word = '0;
      word[SW-1:0] = vec_buf[i];
      in_tvalid <= 1'b1;
      in_tdata  <= word;
      in_tlast  <= (i == vec_buf.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    elems_sent += vec_buf.size();
    vectors_sent++;
    if (vec_buf.size() == 1)
      singles++;
    vec_buf.delete();
  endtask

  // Sender holds off until every predicted result has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic build_random_vector();
    int len;
    int r;
    sample_mix_t mix;
    r = $urandom_range(0, 99);
    if (r < 8)
      len = 1;
    else if (r < 80)
      len = $urandom_range(2, 6);
    else if (r < 95)
      len = $urandom_range(7, 20);
    else
      len = $urandom_range(21, 60);
    mix = sample_mix_t'($urandom_range(0, 3));
    repeat (len) vec_buf.push_back(pick_sample(mix));
  endtask

  task automatic run_phase(input int send_idle, input int recv_stall);
    int start_count;
    start_count = elems_sent;
    idle_pct = send_idle;
    stall_pct <= recv_stall;
    while (elems_sent - start_count < PHASE_ITEMS) begin
      build_random_vector();
      send_vector();
      if ($urandom_range(0, 39) == 0)
        wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-variable vectors (error status), extremes, the minimum at (1,1)
    vec_buf = '{X_ZERO};                send_vector();
    vec_buf = '{X_MIN};                 send_vector();
    vec_buf = '{X_MAX};                 send_vector();
    vec_buf = '{X_ZERO, X_ZERO};        send_vector();
    vec_buf = '{X_ONE, X_ONE};          send_vector();
    vec_buf = '{X_MIN, X_MIN};          send_vector();
    vec_buf = '{X_MAX, X_MIN};          send_vector();
    vec_buf = '{X_MIN, X_MAX};          send_vector();
    vec_buf = '{X_MAX, X_MAX, X_MAX};   send_vector();
    vec_buf = '{X_NEG1, X_LSB, X_NEG1, X_LSB}; send_vector();
    wait_drained();

    // random vectors under each handshake mix
    run_phase(0, 0);
    run_phase(81, 0);
    run_phase(0, 81);
    run_phase(32, 32);

    repeat (20) @(posedge clk);
    $display("Run covered %0d variables in %0d vectors (%0d with a single variable),",
             elems_sent, vectors_sent, singles);
    $display("with %0d results checked over free-running, idle, stall and mixed phases.",
             results_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
